[rtl/dns_query_parser_defines.svh]
// assertion macros for the dns query parser
`ifndef DNS_QUERY_PARSER_DEFINES_SVH
`define DNS_QUERY_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define DQP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dqp: implication check failed");
`define DQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dqp: next-cycle check failed");
`else
`define DQP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DQP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/dqp_pkg.sv]
`default_nettype none

package dqp_pkg;

    localparam int HDR_BYTES  = 12;
    localparam int HDR_WORDS  = 6;
    localparam int TAIL_BYTES = 4;
    localparam int CNT_W      = 4;
    localparam int Q_DEPTH    = 4;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_CHAR     = 3'd1,
        KIND_QUESTION = 3'd2,
        KIND_ACCEPT   = 3'd3,
        KIND_REJECT   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_char;
        logic [15:0] rec_type;
        logic [15:0] rec_class;
        logic [15:0] q_index;
    } t_res;

    // up to two results per received byte, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_slots;

    typedef struct packed {
        logic [HDR_WORDS-1:0][15:0] hdr;
        t_slots                     slots;
    } t_cmd;

    function automatic t_res make_res(input t_kind kind, input logic [7:0] ch,
                                      input logic [15:0] rtype, input logic [15:0] rclass,
                                      input logic [15:0] qidx);
        t_res r;
        r.kind      = kind;
        r.name_char = ch;
        r.rec_type  = rtype;
        r.rec_class = rclass;
        r.q_index   = qidx;
        return r;
    endfunction

    function automatic t_slots add_res(input t_slots s, input t_res x);
        t_slots o;
        o = s;
        if (s.cnt == 2'd0) begin
            o.r0 = x;
        end else begin
            o.r1 = x;
        end
        o.cnt = s.cnt + 2'd1;
        return o;
    endfunction

endpackage

`default_nettype wire

[rtl/dqp_fifo.sv]
`default_nettype none
`include "dns_query_parser_defines.svh"

module dqp_fifo #(
    parameter int DEPTH = dqp_pkg::Q_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire dqp_pkg::t_cmd i_cmd,
    input  wire logic          i_rd,
    output dqp_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dqp_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic wr_en, rd_en;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `DQP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `DQP_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, wr_en && !rd_en, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

[rtl/dqp_front.sv]
`default_nettype none
`include "dns_query_parser_defines.svh"

module dqp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    output logic               o_wr,
    output dqp_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_LABEL  = 5'b00100,
        PH_TAIL   = 5'b01000,
        PH_WAIT   = 5'b10000
    } t_phase;

    t_phase r_phase, n_phase;
    logic [dqp_pkg::CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [dqp_pkg::HDR_WORDS-1:0][15:0] r_hdr, n_hdr;
    logic [7:0]  r_label, n_label;
    logic        r_started, n_started;
    logic [15:0] r_cur_q, n_cur_q;
    logic [23:0] r_tail, n_tail;
    logic [15:0] next_q;
    dqp_pkg::t_slots slots;

    assign next_q = r_cur_q + 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_hdr      = r_hdr;
        n_label    = r_label;
        n_started  = r_started;
        n_cur_q    = r_cur_q;
        n_tail     = r_tail;
        slots      = '0;
        if (i_valid) begin
            case (r_phase)
                PH_HEADER: begin
                    for (int i = 0; i < dqp_pkg::HDR_WORDS; i++) begin
                        if (r_byte_cnt[dqp_pkg::CNT_W-1:1] == 3'(i)) begin
                            n_hdr[i] = {r_hdr[i][7:0], i_data_byte};
                        end
                    end
                    if (r_byte_cnt == dqp_pkg::CNT_W'(dqp_pkg::HDR_BYTES - 1)) begin
                        slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                            dqp_pkg::KIND_HEADER, 8'd0, 16'd0, 16'd0, 16'd0));
                        n_byte_cnt = '0;
                        n_cur_q    = '0;
                        n_started  = 1'b0;
                        if (r_hdr[2] == 16'd0) begin
                            slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                                dqp_pkg::KIND_ACCEPT, 8'd0, 16'd0, 16'd0, 16'd0));
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_LENGTH;
                        end
                    end else begin
                        n_byte_cnt = r_byte_cnt + 1'b1;
                    end
                end
                PH_LENGTH: begin
                    if (i_data_byte == 8'd0) begin
                        if (!r_started) begin
                            // empty name
                            slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                                dqp_pkg::KIND_REJECT, 8'd0, 16'd0, 16'd0, r_cur_q));
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase    = PH_TAIL;
                            n_byte_cnt = '0;
                        end
                    end else begin
                        if (r_started) begin
                            slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                                dqp_pkg::KIND_CHAR, 8'h2e, 16'd0, 16'd0, r_cur_q));
                        end
                        n_started = 1'b1;
                        n_label   = i_data_byte;
                        n_phase   = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                        dqp_pkg::KIND_CHAR, i_data_byte, 16'd0, 16'd0, r_cur_q));
                    n_label = r_label - 8'd1;
                    if (r_label == 8'd1) begin
                        n_phase = PH_LENGTH;
                    end
                end
                PH_TAIL: begin
                    n_tail     = {r_tail[15:0], i_data_byte};
                    n_byte_cnt = r_byte_cnt + 1'b1;
                    if (r_byte_cnt == dqp_pkg::CNT_W'(dqp_pkg::TAIL_BYTES - 1)) begin
                        slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                            dqp_pkg::KIND_QUESTION, 8'd0, r_tail[23:8],
                            {r_tail[7:0], i_data_byte}, r_cur_q));
                        n_cur_q    = next_q;
                        n_byte_cnt = '0;
                        n_started  = 1'b0;
                        if (next_q == r_hdr[2]) begin
                            slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                                dqp_pkg::KIND_ACCEPT, 8'd0, 16'd0, 16'd0, next_q));
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_LENGTH;
                        end
                    end
                end
                PH_WAIT: begin
                    n_phase = PH_WAIT;
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
            if (i_last_byte) begin
                if (n_phase != PH_WAIT) begin
                    slots = dqp_pkg::add_res(slots, dqp_pkg::make_res(
                        dqp_pkg::KIND_REJECT, 8'd0, 16'd0, 16'd0, n_cur_q));
                end
                n_phase    = PH_HEADER;
                n_byte_cnt = '0;
                n_label    = '0;
                n_started  = 1'b0;
                n_cur_q    = '0;
                n_tail     = '0;
            end
        end
    end

    assign o_wr        = i_valid && (slots.cnt != 2'd0);
    assign o_cmd.hdr   = n_hdr;
    assign o_cmd.slots = slots;

    always_ff @(posedge i_clk) begin
        r_hdr  <= n_hdr;
        r_tail <= n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_byte_cnt <= '0;
            r_label    <= '0;
            r_started  <= 1'b0;
            r_cur_q    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_label    <= n_label;
            r_started  <= n_started;
            r_cur_q    <= n_cur_q;
        end
    end

    `DQP_ASSERT_IMP(a_tail_cnt, i_clk, i_rst_n, r_phase == PH_TAIL, r_byte_cnt < dqp_pkg::CNT_W'(dqp_pkg::TAIL_BYTES))

endmodule

`default_nettype wire

[rtl/dqp_back.sv]
`default_nettype none
`include "dns_query_parser_defines.svh"

module dqp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire dqp_pkg::t_cmd i_head,
    output logic               o_rd,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [2:0]         o_kind,
    output logic [dqp_pkg::HDR_WORDS-1:0][15:0] o_hdr,
    output logic [7:0]         o_name_char,
    output logic [15:0]        o_rec_type,
    output logic [15:0]        o_rec_class,
    output logic [15:0]        o_q_index,
    output logic               o_final
);

    logic r_valid, r_sel;
    dqp_pkg::t_res r_res, sel_res;
    logic [dqp_pkg::HDR_WORDS-1:0][15:0] r_hdr;
    logic r_final;
    logic load, two, last_of_entry;

    assign two           = (i_head.slots.cnt == 2'd2);
    assign last_of_entry = r_sel || !two;
    assign sel_res       = r_sel ? i_head.slots.r1 : i_head.slots.r0;
    assign load          = !i_empty && (!r_valid || i_pop);
    assign o_rd          = load && last_of_entry;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res   <= sel_res;
            r_hdr   <= (sel_res.kind == dqp_pkg::KIND_HEADER) ? i_head.hdr : '0;
            r_final <= last_of_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= !last_of_entry;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_res.kind;
    assign o_hdr       = r_hdr;
    assign o_name_char = r_res.name_char;
    assign o_rec_type  = r_res.rec_type;
    assign o_rec_class = r_res.rec_class;
    assign o_q_index   = r_res.q_index;
    assign o_final     = r_final;

    `DQP_ASSERT_IMP(a_second_slot, i_clk, i_rst_n, r_sel, !i_empty && (i_head.slots.cnt == 2'd2))

endmodule

`default_nettype wire

[rtl/dns_query_parser.sv]
// channel   direction  handshake               payload
// input     in         push / full             i_data_byte, i_last_byte
// result    out        empty / pop             o_kind ... o_final_result
//
// one datagram byte is taken per cycle while full is low; a byte gives zero to two words
// the parser decides a byte in the cycle it is taken; its words pass a small command queue
// a byte that gives two words holds the queue head until both words are in the result register
// the result register shows a word the cycle after it is taken from the queue head and loads on pop or when empty
// full rises only when the command queue is full; synchronous active-low reset empties all
`default_nettype none

module dns_query_parser #(
    parameter int Q_DEPTH = dqp_pkg::Q_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input side
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_kind,
    output logic [15:0]      o_trans_id,
    output logic [15:0]      o_flag_bits,
    output logic [15:0]      o_question_total,
    output logic [15:0]      o_answer_total,
    output logic [15:0]      o_authority_total,
    output logic [15:0]      o_additional_total,
    output logic [7:0]       o_name_char,
    output logic [15:0]      o_record_type,
    output logic [15:0]      o_record_class,
    output logic [15:0]      o_question_index,
    output logic             o_final_result
);

    logic          accept;
    logic          q_wr, q_rd, q_empty, q_full;
    dqp_pkg::t_cmd q_in, q_head;
    logic          out_valid;
    logic [dqp_pkg::HDR_WORDS-1:0][15:0] hdr;

    assign full   = q_full;
    assign accept = push && !q_full;

    // front: header collection, label walk, type and class gathering
    dqp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_wr        (q_wr),
        .o_cmd       (q_in)
    );

    // decoupling queue of per-byte commands
    dqp_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (q_in),
        .i_rd    (q_rd),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: splits commands into result words behind an output register
    dqp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_rd        (q_rd),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_kind      (o_kind),
        .o_hdr       (hdr),
        .o_name_char (o_name_char),
        .o_rec_type  (o_record_type),
        .o_rec_class (o_record_class),
        .o_q_index   (o_question_index),
        .o_final     (o_final_result)
    );

    assign empty              = !out_valid;
    // header words in datagram order
    assign o_trans_id         = hdr[0];
    assign o_flag_bits        = hdr[1];
    assign o_question_total   = hdr[2];
    assign o_answer_total     = hdr[3];
    assign o_authority_total  = hdr[4];
    assign o_additional_total = hdr[5];

endmodule

`default_nettype wire

[test/tb_dns_query_parser.sv]
module tb_dns_query_parser;
    timeunit 1ns;
    timeprecision 1ps;

    // run length
    localparam int RANDOM_BYTES = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    // one result word as the block presents it
    // hdr[0] is the transaction id, hdr[5] the additional record count
    typedef struct packed {
        dqp_pkg::t_kind    kind;
        logic [5:0][15:0]  hdr;
        logic [7:0]        name_char;
        logic [15:0]       rec_type;
        logic [15:0]       rec_class;
        logic [15:0]       q_index;
        logic              final_res;
    } t_dns_word;

    // one row of the directed table; typed rows carry their own single expected word
    typedef struct packed {
        logic [7:0]     data;
        logic           last;
        logic           typed;
        dqp_pkg::t_kind kind;
        logic [15:0]    qidx;
    } t_stim_row;

    // where the parser stands inside the datagram
    typedef enum logic [4:0] {
        SEEK_HEADER = 5'b00001,
        SEEK_LENGTH = 5'b00010,
        IN_LABEL    = 5'b00100,
        IN_TAIL     = 5'b01000,
        SKIP_REST   = 5'b10000
    } t_parse_state;

    // directed datagrams:
    //   a two-byte datagram, too short for a header
    //   a header with extreme words and two questions, the first one with two one-byte
    //   labels and extreme type and class, the second one with an empty name,
    //   then a trailing byte after the rejection that carries the last mark
    localparam t_stim_row DIRECTED_ROWS [0:24] = '{
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b1, 1'b1, dqp_pkg::KIND_REJECT, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h02, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h01, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h01, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'hff, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b0, dqp_pkg::KIND_HEADER, 16'd0},
        '{8'h00, 1'b0, 1'b1, dqp_pkg::KIND_REJECT, 16'd1},
        '{8'h00, 1'b1, 1'b0, dqp_pkg::KIND_HEADER, 16'd0}
    };

    // clock, reset and block ports; every input known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_kind;
    logic [15:0] o_trans_id;
    logic [15:0] o_flag_bits;
    logic [15:0] o_question_total;
    logic [15:0] o_answer_total;
    logic [15:0] o_authority_total;
    logic [15:0] o_additional_total;
    logic [7:0]  o_name_char;
    logic [15:0] o_record_type;
    logic [15:0] o_record_class;
    logic [15:0] o_question_index;
    logic        o_final_result;

    // parser shadow state
    t_parse_state parse_state;
    logic [3:0]   byte_count;
    logic [15:0]  hdr_words [6];
    logic [7:0]   label_left;
    logic         in_name;
    logic [15:0]  question_no;
    logic [31:0]  tail_acc;

    t_dns_word   byte_words[$];     // words caused by the byte being predicted
    t_dns_word   pending_words[$];  // words still owed by the block, oldest first
    logic [7:0]  dgram[$];          // datagram under construction
    int          n_mismatch = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    dns_query_parser u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .empty              (empty),
        .pop                (pop),
        .o_kind             (o_kind),
        .o_trans_id         (o_trans_id),
        .o_flag_bits        (o_flag_bits),
        .o_question_total   (o_question_total),
        .o_answer_total     (o_answer_total),
        .o_authority_total  (o_authority_total),
        .o_additional_total (o_additional_total),
        .o_name_char        (o_name_char),
        .o_record_type      (o_record_type),
        .o_record_class     (o_record_class),
        .o_question_index   (o_question_index),
        .o_final_result     (o_final_result)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // run guard: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // back to the state of a fresh datagram
    function automatic void clear_parser();
        parse_state = SEEK_HEADER;
        byte_count  = '0;
        for (int k = 0; k < 6; k++) begin
            hdr_words[k] = '0;
        end
        label_left  = '0;
        in_name     = 1'b0;
        question_no = '0;
        tail_acc    = '0;
    endfunction

    // header words only with a header word, question number with every other kind
    function automatic void add_word(input dqp_pkg::t_kind k, input logic [7:0] ch,
                                     input logic [31:0] tl);
        t_dns_word w;
        w = '0;
        w.kind = k;
        if (k == dqp_pkg::KIND_HEADER) begin
            for (int k2 = 0; k2 < 6; k2++) begin
                w.hdr[k2] = hdr_words[k2];
            end
        end else begin
            w.q_index = question_no;
        end
        if (k == dqp_pkg::KIND_CHAR) begin
            w.name_char = ch;
        end
        if (k == dqp_pkg::KIND_QUESTION) begin
            w.rec_type  = tl[31:16];
            w.rec_class = tl[15:0];
        end
        byte_words = {byte_words, w};
    endfunction

    // shadow parser: words caused by one accepted byte land in byte_words
    function automatic void parse_byte(input logic [7:0] b, input logic is_last);
        byte_words.delete();
        case (parse_state)
            SEEK_HEADER: begin
                // header words are big-endian, two bytes each
                hdr_words[byte_count[3:1]] = {hdr_words[byte_count[3:1]][7:0], b};
                if (byte_count >= 4'(dqp_pkg::HDR_BYTES - 1)) begin
                    add_word(dqp_pkg::KIND_HEADER, 8'h00, 32'h0);
                    byte_count  = '0;
                    question_no = '0;
                    in_name     = 1'b0;
                    if (hdr_words[2] == 16'h0) begin
                        add_word(dqp_pkg::KIND_ACCEPT, 8'h00, 32'h0);
                        parse_state = SKIP_REST;
                    end else begin
                        parse_state = SEEK_LENGTH;
                    end
                end else begin
                    byte_count = byte_count + 4'd1;
                end
            end
            SEEK_LENGTH: begin
                if (b == 8'h00) begin
                    if (!in_name) begin
                        // empty name rejects the whole datagram
                        add_word(dqp_pkg::KIND_REJECT, 8'h00, 32'h0);
                        parse_state = SKIP_REST;
                    end else begin
                        parse_state = IN_TAIL;
                        byte_count  = '0;
                        tail_acc    = '0;
                    end
                end else begin
                    if (in_name) begin
                        add_word(dqp_pkg::KIND_CHAR, 8'h2e, 32'h0);
                    end
                    in_name     = 1'b1;
                    label_left  = b;
                    parse_state = IN_LABEL;
                end
            end
            IN_LABEL: begin
                add_word(dqp_pkg::KIND_CHAR, b, 32'h0);
                label_left = label_left - 8'd1;
                if (label_left == 8'd0) begin
                    parse_state = SEEK_LENGTH;
                end
            end
            IN_TAIL: begin
                tail_acc   = {tail_acc[23:0], b};
                byte_count = byte_count + 4'd1;
                if (byte_count >= 4'(dqp_pkg::TAIL_BYTES)) begin
                    add_word(dqp_pkg::KIND_QUESTION, 8'h00, tail_acc);
                    question_no = question_no + 16'd1;
                    byte_count  = '0;
                    in_name     = 1'b0;
                    if (question_no == hdr_words[2]) begin
                        add_word(dqp_pkg::KIND_ACCEPT, 8'h00, 32'h0);
                        parse_state = SKIP_REST;
                    end else begin
                        parse_state = SEEK_LENGTH;
                    end
                end
            end
            default: begin
                parse_state = SKIP_REST;
            end
        endcase
        // datagram ended before the question section was complete
        if (is_last) begin
            if (parse_state != SKIP_REST) begin
                add_word(dqp_pkg::KIND_REJECT, 8'h00, 32'h0);
            end
            clear_parser();
        end
        if (byte_words.size() > 0) begin
            byte_words[byte_words.size() - 1].final_res = 1'b1;
        end
    endfunction

    // offer one byte in bursts with random gaps; returns at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input dqp_pkg::t_kind tk, input logic [15:0] tq);
        int gap;
        t_dns_word w;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        // byte taken at this edge
        parse_byte(b, l);
        if (typed) begin
            w = '0;
            w.kind      = tk;
            w.q_index   = tq;
            w.final_res = 1'b1;
            pending_words = {pending_words, w};
        end else begin
            foreach (byte_words[k]) begin
                pending_words = {pending_words, byte_words[k]};
            end
        end
    endtask

    // sender stops offering until every owed word has come out
    task automatic drain_results();
        push <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_words.size() != 0);
    endtask

    // one random datagram: mostly well formed, some noise, early ends and empty names
    task automatic build_datagram();
        int mode;
        int qn;
        int bad_q;
        int len;
        int cut;
        logic [15:0] hw;
        dgram.delete();
        mode = $urandom_range(0, 99);
        if (mode < 10) begin
            // noise: random header, random question section
            repeat ($urandom_range(1, 30)) dgram = {dgram, 8'($urandom)};
            return;
        end
        qn    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        bad_q = (mode < 20) ? $urandom_range(0, 2) : 99;
        for (int k = 0; k < 6; k++) begin
            hw = (k == 2) ? 16'(qn) : 16'($urandom);
            dgram = {dgram, hw[15:8], hw[7:0]};
        end
        for (int q = 0; q < qn; q++) begin
            if (q == bad_q) begin
                dgram = {dgram, 8'h00};
                break;
            end
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 99))
                    0:       len = 255;
                    1, 2:    len = 63;
                    default: len = $urandom_range(1, 8);
                endcase
                dgram = {dgram, 8'(len)};
                repeat (len) dgram = {dgram, 8'($urandom)};
            end
            dgram = {dgram, 8'h00};
            repeat (dqp_pkg::TAIL_BYTES) dgram = {dgram, 8'($urandom)};
        end
        // trailing bytes after the question section
        repeat ($urandom_range(0, 3)) dgram = {dgram, 8'($urandom)};
        if (mode >= 20 && mode < 32) begin
            // early end anywhere, short header included
            cut = $urandom_range(1, dgram.size() - 1);
            while (dgram.size() > cut) begin
                void'(dgram.pop_back());
            end
        end
    endtask

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin : rx_side
        int mode;
        int mode_left;
        int hold_left;
        int phase_cnt;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        phase_cnt = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            phase_cnt = phase_cnt + 1;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 100);
                end
                mode_left = mode_left - 1;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (phase_cnt % 3 == 0);
                endcase
            end
        end
    end

    // mismatch report, first ten in full
    function automatic void flag_mismatch(input string what, input t_dns_word want,
                                          input t_dns_word got);
        n_mismatch = n_mismatch + 1;
        if (n_mismatch <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  expected kind %0d hdr %h char %h type %h class %h q %0d last %b",
                     want.kind, want.hdr, want.name_char, want.rec_type, want.rec_class,
                     want.q_index, want.final_res);
            $display("  actual   kind %0d hdr %h char %h type %h class %h q %0d last %b",
                     got.kind, got.hdr, got.name_char, got.rec_type, got.rec_class,
                     got.q_index, got.final_res);
        end
    endfunction

    // result side: every word taken is checked against the oldest owed word
    always @(posedge i_clk) begin : result_check
        t_dns_word got;
        t_dns_word want;
        if (i_rst_n && pop && !empty) begin
            got.kind      = dqp_pkg::t_kind'(o_kind);
            got.hdr[0]    = o_trans_id;
            got.hdr[1]    = o_flag_bits;
            got.hdr[2]    = o_question_total;
            got.hdr[3]    = o_answer_total;
            got.hdr[4]    = o_authority_total;
            got.hdr[5]    = o_additional_total;
            got.name_char = o_name_char;
            got.rec_type  = o_record_type;
            got.rec_class = o_record_class;
            got.q_index   = o_question_index;
            got.final_res = o_final_result;
            if (pending_words.size() == 0) begin
                flag_mismatch("word with none owed", '0, got);
            end else begin
                want = pending_words.pop_front();
                if (got.kind !== want.kind || got.hdr !== want.hdr
                    || got.name_char !== want.name_char || got.rec_type !== want.rec_type
                    || got.rec_class !== want.rec_class || got.q_index !== want.q_index
                    || got.final_res !== want.final_res) begin
                    flag_mismatch("word differs", want, got);
                end
            end
        end
    end

    // sender: reset, directed table, then random datagrams
    initial begin : tx_side
        int random_sent;
        bit first_hold;
        bit second_hold;
        bit first_drain;
        bit second_drain;
        random_sent  = 0;
        first_hold   = 1'b0;
        second_hold  = 1'b0;
        first_drain  = 1'b0;
        second_drain = 1'b0;
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].qidx);
        end

        while (random_sent < RANDOM_BYTES) begin
            // long receiver hold-offs while bytes keep coming, so the queue fills up
            if (!first_hold && random_sent >= 300) begin
                first_hold = 1'b1;
                hold_req   = 1'b1;
            end
            if (!second_hold && random_sent >= 1200) begin
                second_hold = 1'b1;
                hold_req    = 1'b1;
            end
            // at two points in the run the sender waits out every owed word between datagrams
            if (!first_drain && random_sent >= 700) begin
                first_drain = 1'b1;
                drain_results();
            end
            if (!second_drain && random_sent >= 1600) begin
                second_drain = 1'b1;
                drain_results();
            end
            build_datagram();
            foreach (dgram[k]) begin
                send_byte(dgram[k], k == dgram.size() - 1, 1'b0, dqp_pkg::KIND_HEADER, 16'd0);
            end
            random_sent = random_sent + dgram.size();
        end

        push <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        // give a stray extra word time to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[dns_query_parser.f]
+incdir+rtl
rtl/dqp_pkg.sv
rtl/dqp_fifo.sv
rtl/dqp_front.sv
rtl/dqp_back.sv
rtl/dns_query_parser.sv
test/tb_dns_query_parser.sv
